// ----- hdl/cct_pkg.sv -----
package cct_pkg;

	// lexer states, codes above the last member behave as idle
	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_INT   = 3'd1,
		ST_STR   = 3'd2,
		ST_ESC   = 3'd3,
		ST_IDENT = 3'd4
	} lex_state_t;

	// event codes
	localparam logic [1:0] EV_CONTENT = 2'd0;
	localparam logic [1:0] EV_DONE    = 2'd1;
	localparam logic [1:0] EV_ERROR   = 2'd2;

	// token types
	localparam logic [1:0] TY_INT   = 2'd0;
	localparam logic [1:0] TY_STR   = 2'd1;
	localparam logic [1:0] TY_IDENT = 2'd2;
	localparam logic [1:0] TY_END   = 2'd3;

	// character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam int VAL_W = 31;
	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

	// one result item, token length travels beside it
	typedef struct packed {
		logic [1:0]       ev;
		logic [1:0]       ty;
		logic [7:0]       byte_val;
		logic [VAL_W-1:0] val;
	} res_t;

endpackage

// ----- hdl/console_command_tokenizer.sv -----
// Command line tokenizer: one text byte per input transaction, zero to two result
// transactions out. A character is taken into an input register, decoded there
// against the lexer state, and its results land in the output register;
// a second result (a token completed by the byte that also starts the next event,
// e.g. an identifier ended by NUL) waits in a spare register behind it. When every
// byte gives at most one result and the output is not stalled, the block
// sustains one transaction per cycle on both sides; a byte that gives two results
// holds the input register while the spare is full. Blanks separate tokens, digit runs
// form integer tokens saturating at 2^31-1, quoted runs form string tokens (a
// backslash stays as content and protects a following quote), anything else forms
// an identifier. NUL yields an end of line token; NUL inside a string yields an
// error and returns the lexer to its reset state. Content bytes past MAX_TOKEN_LEN
// produce no transaction and token_length stops at MAX_TOKEN_LEN.
module console_command_tokenizer #(
	parameter int MAX_TOKEN_LEN = 64,
	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             character,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             event_res,
	output logic [1:0]             token_kind,
	output logic [7:0]             content_byte,
	output logic [cct_pkg::VAL_W-1:0] int_value,
	output logic [LEN_W-1:0]       token_length,
	output logic                   last
);

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
	localparam int PROD_W = cct_pkg::VAL_W + 4;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;

	// lexer state
	cct_pkg::lex_state_t st_q, st_d;
	logic [cct_pkg::VAL_W-1:0] acc_q, acc_d;
	logic [LEN_W-1:0] len_q, len_d;

	// output register and spare for a second result
	logic                out_valid_q;
	cct_pkg::res_t       out_q;
	logic [LEN_W-1:0]    out_len_q;
	logic                out_last_q;
	logic                sp_valid_q;
	cct_pkg::res_t       sp_q;
	logic [LEN_W-1:0]    sp_len_q;

	// character classes
	logic is_nul, is_blank, is_quote, is_bslash, is_digit;
	logic [3:0] digit;
	logic keep;
	logic [LEN_W-1:0] len_inc;
	logic [PROD_W-1:0] prod;
	logic [cct_pkg::VAL_W-1:0] acc_sat;

	// handshake
	logic go, pop;

	assign is_nul    = (char_s1 == cct_pkg::CH_NUL);
	assign is_blank  = (char_s1 == cct_pkg::CH_SPACE) || (char_s1 == cct_pkg::CH_TAB);
	assign is_quote  = (char_s1 == cct_pkg::CH_QUOTE);
	assign is_bslash = (char_s1 == cct_pkg::CH_BSLASH);
	assign is_digit  = (char_s1 >= cct_pkg::CH_ZERO) && (char_s1 <= cct_pkg::CH_NINE);
	assign digit     = 4'(char_s1 - cct_pkg::CH_ZERO);

	// room left in the token for one more content byte
	assign keep    = (len_q < LEN_MAX);
	assign len_inc = keep ? len_q + LEN_W'(1) : len_q;

	// acc * 10 + digit as two shifts and adds, then saturate
	assign prod = (PROD_W'(acc_q) << 3) + (PROD_W'(acc_q) << 1) + PROD_W'(digit);
	assign acc_sat = (prod > PROD_W'(cct_pkg::VAL_MAX)) ? cct_pkg::VAL_MAX
		: prod[cct_pkg::VAL_W-1:0];

	// a decoded byte moves on only when both output slots can take its results
	assign pop      = out_valid_q && out_ready;
	assign go       = valid_s1 && !sp_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go;

	// ---------------------------------------------------------------------
	// next lexer state
	// ---------------------------------------------------------------------
	cct_pkg::lex_state_t id_st, sn_st;
	logic [cct_pkg::VAL_W-1:0] id_acc;
	logic [LEN_W-1:0] id_len, sn_len;

	// byte handled between tokens, from a cleared token
	always_comb begin
		id_st  = cct_pkg::ST_IDLE;
		id_acc = '0;
		id_len = '0;
		if (is_nul || is_blank) begin
			id_st = cct_pkg::ST_IDLE;
		end else if (is_quote) begin
			id_st = cct_pkg::ST_STR;
		end else if (is_digit) begin
			id_st  = cct_pkg::ST_INT;
			id_acc = cct_pkg::VAL_W'(digit);
			id_len = LEN_W'(1);
		end else begin
			id_st  = cct_pkg::ST_IDENT;
			id_len = LEN_W'(1);
		end
	end

	// byte handled inside a string
	always_comb begin
		sn_st  = cct_pkg::ST_STR;
		sn_len = len_inc;
		if (is_quote || is_nul) begin
			sn_st  = cct_pkg::ST_IDLE;
			sn_len = '0;
		end else if (is_bslash) begin
			sn_st = cct_pkg::ST_ESC;
		end
	end

	always_comb begin
		st_d  = st_q;
		acc_d = acc_q;
		len_d = len_q;
		case (st_q)
			cct_pkg::ST_INT: begin
				if (is_digit) begin
					acc_d = acc_sat;
					len_d = len_inc;
				end else begin
					st_d  = id_st;
					acc_d = id_acc;
					len_d = id_len;
				end
			end
			cct_pkg::ST_IDENT: begin
				if (is_blank || is_nul) begin
					st_d  = id_st;
					acc_d = id_acc;
					len_d = id_len;
				end else begin
					len_d = len_inc;
				end
			end
			cct_pkg::ST_STR: begin
				st_d  = sn_st;
				acc_d = '0;
				len_d = sn_len;
			end
			cct_pkg::ST_ESC: begin
				acc_d = '0;
				if (is_quote) begin
					st_d  = cct_pkg::ST_STR;
					len_d = len_inc;
				end else begin
					st_d  = sn_st;
					len_d = sn_len;
				end
			end
			default: begin
				st_d  = id_st;
				acc_d = id_acc;
				len_d = id_len;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// results of this byte
	// ---------------------------------------------------------------------
	logic             a_v, b_v;
	cct_pkg::res_t    a_res, b_res;
	logic [LEN_W-1:0] a_len;
	cct_pkg::res_t    r0_res;
	logic [LEN_W-1:0] r0_len;
	logic             r0_v, two;

	// result of a byte between tokens (at most one, never clipped)
	always_comb begin
		b_res          = '0;
		b_res.byte_val = char_s1;
		if (is_nul) begin
			b_res.ev       = cct_pkg::EV_DONE;
			b_res.ty       = cct_pkg::TY_END;
			b_res.byte_val = '0;
		end else begin
			b_res.ev = cct_pkg::EV_CONTENT;
			b_res.ty = is_digit ? cct_pkg::TY_INT : cct_pkg::TY_IDENT;
		end
	end

	always_comb begin
		a_v   = 1'b0;
		b_v   = 1'b0;
		a_res = '0;
		a_len = '0;
		case (st_q)
			cct_pkg::ST_INT: begin
				if (is_digit) begin
					a_v            = keep;
					a_res.ev       = cct_pkg::EV_CONTENT;
					a_res.ty       = cct_pkg::TY_INT;
					a_res.byte_val = char_s1;
				end else begin
					// integer completed, terminator then handled as between tokens
					a_v       = 1'b1;
					a_res.ev  = cct_pkg::EV_DONE;
					a_res.ty  = cct_pkg::TY_INT;
					a_res.val = acc_q;
					a_len     = len_q;
					b_v       = !is_blank && !is_quote;
				end
			end
			cct_pkg::ST_IDENT: begin
				if (is_blank || is_nul) begin
					a_v      = 1'b1;
					a_res.ev = cct_pkg::EV_DONE;
					a_res.ty = cct_pkg::TY_IDENT;
					a_len    = len_q;
					b_v      = is_nul;
				end else begin
					a_v            = keep;
					a_res.ev       = cct_pkg::EV_CONTENT;
					a_res.ty       = cct_pkg::TY_IDENT;
					a_res.byte_val = char_s1;
				end
			end
			cct_pkg::ST_STR, cct_pkg::ST_ESC: begin
				a_res.ty = cct_pkg::TY_STR;
				if (is_quote && st_q == cct_pkg::ST_STR) begin
					a_v      = 1'b1;
					a_res.ev = cct_pkg::EV_DONE;
					a_len    = len_q;
				end else if (is_nul) begin
					// unterminated string
					a_v      = 1'b1;
					a_res.ev = cct_pkg::EV_ERROR;
				end else begin
					// escaped quote and any other byte are content
					a_v            = keep;
					a_res.ev       = cct_pkg::EV_CONTENT;
					a_res.byte_val = char_s1;
				end
			end
			default: begin
				b_v = !is_blank && !is_quote;
			end
		endcase
	end

	assign r0_v   = a_v || b_v;
	assign two    = a_v && b_v;
	assign r0_res = a_v ? a_res : b_res;
	assign r0_len = a_v ? a_len : '0;

	// ---------------------------------------------------------------------
	// registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= cct_pkg::ST_IDLE;
			acc_q <= '0;
			len_q <= '0;
		end else if (go) begin
			st_q  <= st_d;
			acc_q <= acc_d;
			len_q <= len_d;
		end
	end

	// output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sp_valid_q  <= 1'b0;
		end else if (go) begin
			out_valid_q <= r0_v || (out_valid_q && !pop);
			sp_valid_q  <= two;
		end else if (pop) begin
			out_valid_q <= sp_valid_q;
			sp_valid_q  <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (go && r0_v) begin
			out_q      <= r0_res;
			out_len_q  <= r0_len;
			out_last_q <= !two;
		end else if (pop && sp_valid_q) begin
			out_q      <= sp_q;
			out_len_q  <= sp_len_q;
			out_last_q <= 1'b1;
		end
		if (go && two) begin
			sp_q     <= b_res;
			sp_len_q <= '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = out_q.ev;
	assign token_kind   = out_q.ty;
	assign content_byte = out_q.byte_val;
	assign int_value    = out_q.val;
	assign token_length = out_len_q;
	assign last         = out_last_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sp_valid_q |-> out_valid_q && !out_last_q)
		else $error("spare result held without a pending first result");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == cct_pkg::ST_IDLE |-> acc_q == '0 && len_q == '0)
		else $error("lexer idle with leftover token state");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_MAX)
		else $error("kept length above maximum");

	a_error_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.ev == cct_pkg::EV_ERROR |->
			out_q.ty == cct_pkg::TY_STR && out_last_q)
		else $error("malformed error result");

	a_no_go_with_spare: assert property (@(posedge clk) disable iff (!arst_n)
		sp_valid_q |=> !$past(go))
		else $error("byte decoded while spare result pending");

endmodule

// ----- test/console_command_tokenizer_tb.sv -----
module console_command_tokenizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN = 64;
	localparam int LEN_BITS = $clog2(MAX_LEN + 1);
	localparam int VAL_BITS = cct_pkg::VAL_W;
	// limit far above the slowest correct run, this leaves lots of room
	localparam int CYCLE_LIMIT = 200000;
	// output register plus the spare one, then some margin
	localparam int DRAIN_CYCLES = 20;
	// long output stall, started once this many results have been checked
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 250;
	// random characters queued per pacing phase
	localparam int PHASE_CHARS = 475;

	// one result transaction as the block presents it
	typedef struct packed {
		logic [1:0]          ev;
		logic [1:0]          ty;
		logic [7:0]          chr;
		logic [VAL_BITS-1:0] val;
		logic [LEN_BITS-1:0] len;
		logic                fin;
	} token_event_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          character = cct_pkg::CH_NUL;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          event_res;
	logic [1:0]          token_kind;
	logic [7:0]          content_byte;
	logic [VAL_BITS-1:0] int_value;
	logic [LEN_BITS-1:0] token_length;
	logic                last;

	console_command_tokenizer #(
		.MAX_TOKEN_LEN(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.character(character),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_res(event_res),
		.token_kind(token_kind),
		.content_byte(content_byte),
		.int_value(int_value),
		.token_length(token_length),
		.last(last)
	);

	// characters waiting for the driver, filled by the stimulus process
	logic [7:0] chars_to_send[$];
	// results still owed by the block, oldest first
	token_event_t token_events_due[$];
	// results of the character being predicted
	token_event_t step_events[$];

	// lexer copy kept by the predictor
	cct_pkg::lex_state_t lex_st = cct_pkg::ST_IDLE;
	logic [VAL_BITS-1:0] int_acc = '0;
	int unsigned         kept_len = 0;

	// idle chances in percent, changed per pacing phase
	int unsigned send_gap_pct = 14;
	int unsigned take_gap_pct = 61;

	int unsigned chars_accepted = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned lines_ended = 0;
	int unsigned string_errors = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit is_blank_char(input logic [7:0] c);
		return c == cct_pkg::CH_SPACE || c == cct_pkg::CH_TAB;
	endfunction

	function automatic bit is_digit_char(input logic [7:0] c);
		return c >= cct_pkg::CH_ZERO && c <= cct_pkg::CH_NINE;
	endfunction

	// ---------------------------------------------------------------- predictor

	task automatic push_event(input logic [1:0] ev, input logic [1:0] ty,
			input logic [7:0] chr, input logic [VAL_BITS-1:0] val, input int unsigned len);
		token_event_t e;
		e.ev = ev;
		e.ty = ty;
		e.chr = chr;
		e.val = val;
		e.len = LEN_BITS'(len);
		e.fin = 1'b0;
		step_events.push_back(e);
	endtask

	task automatic clear_token();
		lex_st = cct_pkg::ST_IDLE;
		int_acc = '0;
		kept_len = 0;
	endtask

	// bytes past the length cap vanish without a transaction
	task automatic keep_content(input logic [1:0] ty, input logic [7:0] c);
		if (kept_len < MAX_LEN) begin
			kept_len++;
			push_event(cct_pkg::EV_CONTENT, ty, c, '0, 0);
		end
	endtask

	task automatic close_token(input logic [1:0] ty);
		push_event(cct_pkg::EV_DONE, ty, cct_pkg::CH_NUL,
			(ty == cct_pkg::TY_INT) ? int_acc : VAL_BITS'(0), kept_len);
		clear_token();
	endtask

	// a character seen between tokens, or the one that just ended a token
	task automatic start_between(input logic [7:0] c);
		if (c == cct_pkg::CH_NUL) begin
			clear_token();
			push_event(cct_pkg::EV_DONE, cct_pkg::TY_END, cct_pkg::CH_NUL, '0, 0);
			lines_ended++;
		end else if (is_blank_char(c)) begin
			// separator, nothing to do
		end else if (c == cct_pkg::CH_QUOTE) begin
			clear_token();
			lex_st = cct_pkg::ST_STR;
		end else if (is_digit_char(c)) begin
			clear_token();
			lex_st = cct_pkg::ST_INT;
			int_acc = VAL_BITS'(c - cct_pkg::CH_ZERO);
			keep_content(cct_pkg::TY_INT, c);
		end else begin
			clear_token();
			lex_st = cct_pkg::ST_IDENT;
			keep_content(cct_pkg::TY_IDENT, c);
		end
	endtask

	task automatic string_char(input logic [7:0] c);
		if (c == cct_pkg::CH_QUOTE) begin
			close_token(cct_pkg::TY_STR);
		end else if (c == cct_pkg::CH_NUL) begin
			// open string at end of line: error and back to reset state
			clear_token();
			push_event(cct_pkg::EV_ERROR, cct_pkg::TY_STR, cct_pkg::CH_NUL, '0, 0);
			string_errors++;
		end else if (c == cct_pkg::CH_BSLASH) begin
			keep_content(cct_pkg::TY_STR, c);
			lex_st = cct_pkg::ST_ESC;
		end else begin
			keep_content(cct_pkg::TY_STR, c);
		end
	endtask

	// works out the results of one accepted character and queues them
	task automatic lex_char(input logic [7:0] c);
		logic [63:0] grown;
		step_events.delete();
		case (lex_st)
			cct_pkg::ST_INT: begin
				if (is_digit_char(c)) begin
					grown = 64'(int_acc) * 64'd10 + 64'(c - cct_pkg::CH_ZERO);
					int_acc = (grown > 64'(cct_pkg::VAL_MAX)) ? cct_pkg::VAL_MAX
						: grown[VAL_BITS-1:0];
					keep_content(cct_pkg::TY_INT, c);
				end else begin
					close_token(cct_pkg::TY_INT);
					start_between(c);
				end
			end
			cct_pkg::ST_IDENT: begin
				if (is_blank_char(c) || c == cct_pkg::CH_NUL) begin
					close_token(cct_pkg::TY_IDENT);
					start_between(c);
				end else begin
					keep_content(cct_pkg::TY_IDENT, c);
				end
			end
			cct_pkg::ST_STR: begin
				string_char(c);
			end
			cct_pkg::ST_ESC: begin
				// quote after a backslash is plain content
				if (c == cct_pkg::CH_QUOTE) begin
					keep_content(cct_pkg::TY_STR, c);
					lex_st = cct_pkg::ST_STR;
				end else begin
					lex_st = cct_pkg::ST_STR;
					string_char(c);
				end
			end
			default: begin
				lex_st = cct_pkg::ST_IDLE;
				start_between(c);
			end
		endcase
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].fin = 1'b1;
		foreach (step_events[i])
			token_events_due.push_back(step_events[i]);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	task automatic check_output();
		token_event_t got;
		token_event_t want;
		got = '{event_res, token_kind, content_byte, int_value, token_length, last};
		results_seen++;
		if (token_events_due.size() == 0) begin
			report_mismatch($sformatf("result %0d with none due: ev=%0d ty=%0d chr=%02h",
				results_seen, got.ev, got.ty, got.chr));
		end else begin
			want = token_events_due.pop_front();
			if (got !== want)
				report_mismatch($sformatf({"result %0d: ev %0d/%0d ty %0d/%0d chr %02h/%02h ",
					"val %0d/%0d len %0d/%0d last %0b/%0b (got/expected)"},
					results_seen, got.ev, want.ev, got.ty, want.ty, got.chr, want.chr,
					got.val, want.val, got.len, want.len, got.fin, want.fin));
		end
	endtask

	// ---------------------------------------------------------------- driver

	// input transactions: valid stays up with a fixed character until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			character <= cct_pkg::CH_NUL;
		end else begin
			if (in_valid && in_ready) begin
				lex_char(character);
				chars_accepted++;
			end
			// free to move on when nothing is offered or the offer was taken
			if (!in_valid || in_ready) begin
				if (chars_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					character <= chars_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	// output transactions: checked at the edge that accepts them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_output();
			// one long stall so the block backs up into its input
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= take_gap_pct);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic queue_text(input string s);
		foreach (s[i])
			chars_to_send.push_back(s[i]);
	endtask

	task automatic queue_blanks(input int unsigned lo, input int unsigned hi);
		int unsigned n;
		n = $urandom_range(hi, lo);
		repeat (n)
			chars_to_send.push_back($urandom_range(1) ? cct_pkg::CH_SPACE : cct_pkg::CH_TAB);
	endtask

	// one well formed token, mostly short, now and then past the length cap
	task automatic queue_token();
		int unsigned kind;
		int unsigned len;
		int unsigned pick;
		logic [7:0]  b;
		kind = $urandom_range(99);
		len = ($urandom_range(29) == 0) ? $urandom_range(72, 60) : $urandom_range(12, 1);
		if (kind < 35) begin
			repeat (len)
				chars_to_send.push_back(cct_pkg::CH_ZERO + 8'($urandom_range(9)));
		end else if (kind < 70) begin
			do
				b = 8'($urandom_range(255, 1));
			while (is_blank_char(b) || is_digit_char(b) || b == cct_pkg::CH_QUOTE);
			chars_to_send.push_back(b);
			repeat (len - 1) begin
				do
					b = 8'($urandom_range(255, 1));
				while (is_blank_char(b));
				chars_to_send.push_back(b);
			end
		end else begin
			chars_to_send.push_back(cct_pkg::CH_QUOTE);
			repeat (len) begin
				pick = $urandom_range(9);
				if (pick == 0) begin
					// escaped quote
					chars_to_send.push_back(cct_pkg::CH_BSLASH);
					chars_to_send.push_back(cct_pkg::CH_QUOTE);
				end else if (pick == 1) begin
					chars_to_send.push_back(cct_pkg::CH_BSLASH);
				end else begin
					do
						b = 8'($urandom_range(255, 1));
					while (b == cct_pkg::CH_QUOTE || b == cct_pkg::CH_BSLASH);
					chars_to_send.push_back(b);
				end
			end
			chars_to_send.push_back(cct_pkg::CH_QUOTE);
		end
	endtask

	// a command line: mostly tokens and blanks, sometimes raw noise or an open string
	task automatic queue_line();
		int unsigned ntok;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(20, 1))
				chars_to_send.push_back(8'($urandom_range(255)));
		end else begin
			queue_blanks(0, 2);
			ntok = $urandom_range(5);
			repeat (ntok) begin
				queue_token();
				// no separator sometimes, so tokens run into each other
				if ($urandom_range(7) != 0)
					queue_blanks(1, 3);
			end
			if ($urandom_range(19) == 0) begin
				chars_to_send.push_back(cct_pkg::CH_QUOTE);
				repeat ($urandom_range(4))
					chars_to_send.push_back(8'($urandom_range(255, 1)));
			end
		end
		chars_to_send.push_back(cct_pkg::CH_NUL);
	endtask

	// waits until every queued character went in and every result came out,
	// sampled between edges so the driver's updates have settled
	task automatic drain_block();
		while (chars_to_send.size() != 0 || in_valid)
			@(negedge clk);
		while (token_events_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int unsigned target;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: saturated integer ended by tab, identifier with a high byte
		// ended by end of line, string with escaped quote and plain backslash,
		// end of line right after a backslash inside a string, blank line
		queue_text("9999999999");
		chars_to_send.push_back(cct_pkg::CH_TAB);
		queue_text("a");
		chars_to_send.push_back(8'hFF);
		chars_to_send.push_back(cct_pkg::CH_NUL);
		queue_text("\"\\\"\\x\"");
		queue_text("\"\\");
		chars_to_send.push_back(cct_pkg::CH_NUL);
		chars_to_send.push_back(cct_pkg::CH_SPACE);
		chars_to_send.push_back(cct_pkg::CH_NUL);

		// three pacing phases, each ends with the sender waiting for a clean drain
		for (int phase = 0; phase < 3; phase++) begin
			target = chars_to_send.size() + PHASE_CHARS;
			while (chars_to_send.size() < target)
				queue_line();
			drain_block();
			@(posedge clk);
			send_gap_pct <= (phase == 0) ? 61 : 0;
			take_gap_pct <= (phase == 0) ? 14 : 0;
		end

		// anything the block still sends now is unexpected
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d characters over three pacing phases and one long output stall",
			chars_accepted);
		$display("checked %0d result transactions: %0d end of line, %0d open string errors",
			results_seen, lines_ended, string_errors);
		if (mismatches == 0 && token_events_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still due", cycle_count,
			token_events_due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
